/* hdl/arp_pkg.sv */
// Package for the ASCII radix integer parser.
// Holds parser phase and radix types, character codes, status codes,
// the result struct and the digit decode and radix scale functions; depends on nothing.
package arp_pkg;

    localparam int MAG_W = 33;
    localparam int PROD_W = MAG_W + 3;

    localparam logic [MAG_W-1:0] MAG_CAP = 33'h0_8000_0000;

    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    localparam logic [4:0] NO_DIGIT = 5'd16;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR  = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_ZERO   = 4'b0010,
        PH_SIGNOK = 4'b0100,
        PH_DIGITS = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_BIN = 2'd1,
        RX_OCT = 2'd2,
        RX_HEX = 2'd3
    } radix_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic [7:0]         bad_byte;
    } result_t;

    function automatic logic [4:0] digit_value(input logic [7:0] c, input radix_t rx);
        logic [4:0] d;
        d = NO_DIGIT;
        if (c inside {[CH_0:CH_9]})
        begin
            d = 5'(c - CH_0);
        end
        else if (rx == RX_HEX && (c inside {[CH_UA:CH_UF]}))
        begin
            d = 5'(c - CH_UA) + 5'd10;
        end
        if (rx == RX_BIN && d > 5'd1)
        begin
            d = NO_DIGIT;
        end
        if (rx == RX_OCT && d > 5'(CH_7 - CH_0))
        begin
            d = NO_DIGIT;
        end
        return d;
    endfunction

    function automatic logic [PROD_W-1:0] scale_mag(input logic [MAG_W-1:0] m,
                                                    input radix_t rx);
        logic [PROD_W-1:0] w;
        logic [PROD_W-1:0] p;
        w = PROD_W'(m);
        case (rx)
            RX_DEC:  p = (w << 3) + (w << 1);
            RX_BIN:  p = w << 1;
            RX_OCT:  p = w << 3;
            RX_HEX:  p = w << 4;
            default: p = (w << 3) + (w << 1);
        endcase
        return p;
    endfunction

endpackage

/* hdl/arp_parser.sv */
// Parser state and per-character step logic of the ASCII radix integer parser.
// Holds phase, radix, sign, saturating magnitude and error flags; builds the
// result for the final character. Depends on arp_pkg.
module arp_parser
    import arp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] char_byte,
    input  logic       last_char,
    output result_t    result
);

    phase_t           phase_reg, phase_next;
    radix_t           radix_reg, radix_next;
    logic             neg_reg, neg_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             range_err_reg, range_err_next;
    logic             char_err_reg, char_err_next;
    logic [7:0]       first_bad_reg, first_bad_next;
    logic             seen_reg, seen_next;

    radix_t            take_rx;
    logic [4:0]        digit;
    logic [PROD_W-1:0] prod;
    logic              sat;
    logic              do_digit;
    logic              do_minus;
    logic              fin_bad;
    logic              fin_range;

    assign take_rx = (phase_reg == PH_START) ? RX_DEC : radix_reg;
    assign digit   = digit_value(char_byte, take_rx);
    assign prod    = scale_mag(mag_reg, take_rx) + PROD_W'(digit);
    assign sat     = prod > PROD_W'(MAG_CAP);

    always_comb
    begin
        phase_next     = phase_reg;
        radix_next     = radix_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        range_err_next = range_err_reg;
        char_err_next  = char_err_reg;
        first_bad_next = first_bad_reg;
        seen_next      = seen_reg;
        do_digit       = 1'b0;
        do_minus       = 1'b0;

        if (!char_err_reg)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (char_byte == CH_B)
                    begin
                        radix_next = RX_BIN;
                        phase_next = PH_SIGNOK;
                    end
                    else if (char_byte == CH_0)
                    begin
                        radix_next = RX_OCT;
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        radix_next = RX_DEC;
                        do_minus   = (char_byte == CH_MINUS);
                        do_digit   = (char_byte != CH_MINUS);
                    end
                end
                PH_ZERO:
                begin
                    if (char_byte == CH_X)
                    begin
                        radix_next = RX_HEX;
                        phase_next = PH_SIGNOK;
                    end
                    else
                    begin
                        do_minus = (char_byte == CH_MINUS);
                        do_digit = (char_byte != CH_MINUS);
                    end
                end
                PH_SIGNOK:
                begin
                    do_minus = (char_byte == CH_MINUS);
                    do_digit = (char_byte != CH_MINUS);
                end
                default:
                begin
                    do_digit = 1'b1;
                end
            endcase
        end

        if (do_minus)
        begin
            neg_next   = 1'b1;
            phase_next = PH_DIGITS;
        end

        if (do_digit)
        begin
            if (digit == NO_DIGIT)
            begin
                char_err_next  = 1'b1;
                first_bad_next = char_byte;
            end
            else
            begin
                mag_next   = sat ? MAG_CAP : prod[MAG_W-1:0];
                if (sat)
                begin
                    range_err_next = 1'b1;
                end
                seen_next  = 1'b1;
                phase_next = PH_DIGITS;
            end
        end
    end

    assign fin_bad   = char_err_next || (neg_next && !seen_next);
    assign fin_range = range_err_next || (!neg_next && mag_next == MAG_CAP);

    always_comb
    begin
        result.value    = '0;
        result.status   = ST_OK;
        result.bad_byte = '0;
        if (fin_bad)
        begin
            result.status   = ST_BAD_CHAR;
            result.bad_byte = char_err_next ? first_bad_next : 8'd0;
        end
        else if (fin_range)
        begin
            result.status = ST_RANGE;
        end
        else
        begin
            result.value = neg_next ? -$signed(mag_next[31:0]) : $signed(mag_next[31:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            radix_reg     <= RX_DEC;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            range_err_reg <= 1'b0;
            char_err_reg  <= 1'b0;
            first_bad_reg <= '0;
            seen_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            if (last_char)
            begin
                phase_reg     <= PH_START;
                radix_reg     <= RX_DEC;
                neg_reg       <= 1'b0;
                mag_reg       <= '0;
                range_err_reg <= 1'b0;
                char_err_reg  <= 1'b0;
                first_bad_reg <= '0;
                seen_reg      <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                radix_reg     <= radix_next;
                neg_reg       <= neg_next;
                mag_reg       <= mag_next;
                range_err_reg <= range_err_next;
                char_err_reg  <= char_err_next;
                first_bad_reg <= first_bad_next;
                seen_reg      <= seen_next;
            end
        end
    end

endmodule

/* hdl/ascii_radix_integer_parser_unit.sv */
// Top level of the ASCII radix integer parser.
// Holds the input register and the result register around arp_parser.
// Depends on arp_pkg and arp_parser.
//
// The input channel carries one character per transaction (char_byte) with
// last_char set on the final character of a number string. The output
// channel carries one transaction per string: value, status and bad_byte.
// A leading 'b' selects binary, "0x" hex (uppercase digits), a leading '0'
// octal, anything else decimal; one '-' may follow the prefix.
// A transaction completes on a rising edge with valid high and stall low.
// Throughput is one character per cycle while in_stall is low. The result of a
// string is loaded into the result register when its final character moves
// on from the input register.
// When the receiver stalls a pending result, a final character waiting in
// the input register holds, and in_stall rises; other characters still flow.
// Reset clears both valid flags and returns the parser to the start of a
// string with decimal radix and no sign, magnitude or error.
module ascii_radix_integer_parser_unit
    import arp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_byte,
    input  logic               last_char,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic [1:0]         status,
    output logic [7:0]         bad_byte
);

    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    step_result;
    logic       advance;
    logic       accept;

    assign advance  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    arp_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .char_byte (s1_char_reg),
        .last_char (s1_last_reg),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_char_reg <= char_byte;
            s1_last_reg <= last_char;
        end
        if (advance && s1_last_reg)
        begin
            out_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = out_reg.value;
    assign status    = out_reg.status;
    assign bad_byte  = out_reg.bad_byte;

endmodule
